[hw/rtl/ardt_pkg.sv]
package ardt_pkg;

	localparam int ENTRIES       = 16;
	localparam int PAYLOAD_BYTES = 31;

	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int POS_W     = $clog2(PAYLOAD_BYTES + 1);
	localparam int PAY_DEPTH = ENTRIES * PAYLOAD_BYTES;
	localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

	localparam logic [1:0] OP_HDR   = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_IGNORED = 3'd3;
	localparam logic [2:0] ST_READ_OK = 3'd4;
	localparam logic [2:0] ST_BAD_IDX = 3'd5;
	localparam logic [2:0] ST_BYTE    = 3'd6;

	typedef struct packed {
		logic [47:0] addr;
		logic [1:0]  addr_type;
		logic [2:0]  adv_type;
		logic [7:0]  rssi;
		logic [4:0]  len;
	} key_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		key_t             data;
	} key_wr_t;

	typedef struct packed {
		logic              en;
		logic [PAY_AW-1:0] addr;
		logic [7:0]        data;
	} pay_wr_t;

endpackage

[hw/rtl/ardt_tbl.sv]
module ardt_tbl import ardt_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  key_rd_addr,
	input  key_wr_t           key_wr,
	output key_t              key_rd,
	input  logic [PAY_AW-1:0] pay_rd_addr,
	input  pay_wr_t           pay_wr,
	output logic [7:0]        pay_rd
);

	key_t       key_mem [ENTRIES];
	logic [7:0] pay_mem [PAY_DEPTH];

	always_ff @(posedge clk) begin
		if (key_wr.en) begin
			key_mem[key_wr.addr] <= key_wr.data;
		end
		key_rd <= key_mem[key_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pay_wr.en) begin
			pay_mem[pay_wr.addr] <= pay_wr.data;
		end
		pay_rd <= pay_mem[pay_rd_addr];
	end

endmodule

[hw/rtl/advert_report_dedup_table.sv]
// channel   | handshake              | payload
// cfg       | psel/penable/pwrite    | paddr, pwdata, prdata (scan_active at 0)
// in        | in_valid / in_ready    | op, address, addr_kind, adv_type, rssi,
//           |                        | report_len, payload_byte, entry_index,
//           |                        | byte_position
// out       | out_valid / out_ready  | status, slot, entry_*, entry_count, dropped_count
//
// One item at a time. Payload byte, clear and ignored header go from idle to the
// done state. A read first waits in a read state for the registered key and
// payload memory reads. An accepted header goes through a search state; the key search
// reads the key memory one entry per cycle and stops at the first match.
// Reset clears counters and the fill state; the memories are not cleared.
// A result waits in the output register while the next item is accepted; a
// further result waits until that register is taken.
module advert_report_dedup_table import ardt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [47:0]        address,
	input  logic [1:0]         addr_kind,
	input  logic [2:0]         adv_type,
	input  logic signed [7:0]  rssi,
	input  logic [4:0]         report_len,
	input  logic [7:0]         payload_byte,
	input  logic [3:0]         entry_index,
	input  logic [4:0]         byte_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [3:0]         slot,
	output logic [47:0]        entry_address,
	output logic [1:0]         entry_address_type,
	output logic [2:0]         entry_adv_type,
	output logic signed [7:0]  entry_rssi,
	output logic [4:0]         entry_length,
	output logic [7:0]         entry_byte,
	output logic [4:0]         entry_count,
	output logic [31:0]        dropped_count
);

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot;
		key_t        key;
		logic [7:0]  data;
		logic [4:0]  count;
		logic [31:0] dropped;
	} res_t;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic             scan_q;
	logic [CNT_W-1:0] used_q;
	logic [31:0]      drop_q;
	logic [IDX_W-1:0] fill_slot_q;
	logic [POS_W-1:0] fill_pos_q;
	logic [POS_W-1:0] fill_len_q;
	logic             fill_open_q;
	logic [POS_W-1:0] cnt_q [ENTRIES];
	logic [IDX_W-1:0] idx_q;
	key_t             hdr_q;
	logic [3:0]       rd_idx_q;
	logic [4:0]       rd_pos_q;
	res_t             res_q;
	res_t             out_q;
	logic             out_valid_q;

	logic              acc;
	logic              out_free;
	logic              load_out;
	logic              key_hit;
	logic              more;
	logic              room;
	logic [IDX_W-1:0]  wr_slot;
	logic [POS_W-1:0]  fill_next;
	logic [IDX_W-1:0]  key_rd_addr;
	logic [PAY_AW-1:0] pay_rd_addr;
	key_wr_t           key_wr;
	pay_wr_t           pay_wr;
	key_t              key_rd;
	logic [7:0]        pay_rd;
	res_t              rd_res;

	function automatic res_t mk_res(logic [2:0] st, logic [3:0] sl,
			logic [CNT_W-1:0] cnt, logic [31:0] drp);
		res_t r;
		r         = '0;
		r.status  = st;
		r.slot    = sl;
		r.count   = 5'(cnt);
		r.dropped = drp;
		return r;
	endfunction

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {31'd0, scan_q};
	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			scan_q <= pwdata[0];
		end
	end

	assign key_hit = (CNT_W'(idx_q) < used_q) && key_rd.addr == hdr_q.addr &&
		key_rd.addr_type == hdr_q.addr_type && key_rd.adv_type == hdr_q.adv_type;
	assign more      = (CNT_W'(idx_q) + CNT_W'(1)) < used_q;
	assign room      = used_q < CNT_W'(ENTRIES);
	assign wr_slot   = key_hit ? idx_q : IDX_W'(used_q);
	assign fill_next = fill_pos_q + POS_W'(1);

	always_comb begin
		if (state_q == S_SRCH) begin
			key_rd_addr = idx_q + IDX_W'(1);
		end else if (op == OP_READ) begin
			key_rd_addr = IDX_W'(entry_index);
		end else begin
			key_rd_addr = '0;
		end
	end

	assign pay_rd_addr = PAY_AW'(int'(entry_index) * PAYLOAD_BYTES + int'(byte_position));

	assign key_wr.en   = (state_q == S_SRCH) && (key_hit || (!more && room));
	assign key_wr.addr = wr_slot;
	assign key_wr.data = hdr_q;

	assign pay_wr.en   = acc && op == OP_BYTE && fill_open_q;
	assign pay_wr.addr = PAY_AW'(int'(fill_slot_q) * PAYLOAD_BYTES + int'(fill_pos_q));
	assign pay_wr.data = payload_byte;

	ardt_tbl u_tbl (
		.clk         (clk),
		.key_rd_addr (key_rd_addr),
		.key_wr      (key_wr),
		.key_rd      (key_rd),
		.pay_rd_addr (pay_rd_addr),
		.pay_wr      (pay_wr),
		.pay_rd      (pay_rd)
	);

	always_ff @(posedge clk) begin
		if (pay_wr.en) begin
			cnt_q[fill_slot_q] <= fill_next;
		end else if (key_wr.en) begin
			cnt_q[wr_slot] <= '0;
		end
	end

	always_comb begin
		rd_res      = mk_res(ST_READ_OK, rd_idx_q, used_q, drop_q);
		rd_res.key  = key_rd;
		rd_res.data = (rd_pos_q < key_rd.len &&
			int'(rd_pos_q) < int'(cnt_q[IDX_W'(rd_idx_q)])) ? pay_rd : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			drop_q      <= '0;
			fill_slot_q <= '0;
			fill_pos_q  <= '0;
			fill_len_q  <= '0;
			fill_open_q <= 1'b0;
			idx_q       <= '0;
			hdr_q       <= '0;
			rd_idx_q    <= '0;
			rd_pos_q    <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (op)
							OP_HDR: begin
								if (!scan_q) begin
									res_q   <= mk_res(ST_IGNORED, 4'd0, used_q, drop_q);
									state_q <= S_DONE;
								end else if (int'(report_len) > PAYLOAD_BYTES) begin
									fill_open_q <= 1'b0;
									res_q       <= mk_res(ST_IGNORED, 4'd0, used_q, drop_q);
									state_q     <= S_DONE;
								end else begin
									hdr_q   <= '{addr: address, addr_type: addr_kind,
										adv_type: adv_type, rssi: rssi, len: report_len};
									idx_q   <= '0;
									state_q <= S_SRCH;
								end
							end
							OP_BYTE: begin
								state_q <= S_DONE;
								if (!fill_open_q) begin
									res_q <= mk_res(ST_IGNORED, 4'd0, used_q, drop_q);
								end else begin
									fill_pos_q <= fill_next;
									if (fill_next == fill_len_q) begin
										fill_open_q <= 1'b0;
									end
									res_q <= mk_res(ST_BYTE, 4'(fill_slot_q), used_q, drop_q);
								end
							end
							OP_READ: begin
								rd_idx_q <= entry_index;
								rd_pos_q <= byte_position;
								state_q  <= S_READ;
							end
							default: begin
								used_q      <= '0;
								drop_q      <= '0;
								fill_open_q <= 1'b0;
								fill_pos_q  <= '0;
								res_q       <= mk_res(ST_UPDATED, 4'd0, '0, 32'd0);
								state_q     <= S_DONE;
							end
						endcase
					end
				end
				S_SRCH: begin
					if (key_hit || (!more && room)) begin
						fill_slot_q <= wr_slot;
						fill_pos_q  <= '0;
						fill_len_q  <= POS_W'(hdr_q.len);
						fill_open_q <= (hdr_q.len != 5'd0);
						state_q     <= S_DONE;
						if (key_hit) begin
							res_q <= mk_res(ST_UPDATED, 4'(idx_q), used_q, drop_q);
						end else begin
							used_q <= used_q + CNT_W'(1);
							res_q <= mk_res(ST_NEW, 4'(used_q), used_q + CNT_W'(1), drop_q);
						end
					end else if (more) begin
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						fill_open_q <= 1'b0;
						state_q     <= S_DONE;
						if (drop_q != 32'hFFFF_FFFF) begin
							drop_q <= drop_q + 32'd1;
							res_q  <= mk_res(ST_DROPPED, 4'd0, used_q, drop_q + 32'd1);
						end else begin
							res_q  <= mk_res(ST_DROPPED, 4'd0, used_q, drop_q);
						end
					end
				end
				S_READ: begin
					state_q <= S_DONE;
					if (int'(rd_idx_q) >= int'(used_q)) begin
						res_q <= mk_res(ST_BAD_IDX, rd_idx_q, used_q, drop_q);
					end else begin
						res_q <= rd_res;
					end
				end
				default: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = out_q.status;
	assign slot               = out_q.slot;
	assign entry_address      = out_q.key.addr;
	assign entry_address_type = out_q.key.addr_type;
	assign entry_adv_type     = out_q.key.adv_type;
	assign entry_rssi         = $signed(out_q.key.rssi);
	assign entry_length       = out_q.key.len;
	assign entry_byte         = out_q.data;
	assign entry_count        = out_q.count;
	assign dropped_count      = out_q.dropped;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(ENTRIES))
		else $error("entry count above table size");

	a_fill_pos: assert property (@(posedge clk) disable iff (!arst_n)
		fill_open_q |-> fill_pos_q < fill_len_q)
		else $error("open fill past its length");

	a_srch_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH |-> CNT_W'(idx_q) <= used_q)
		else $error("key search beyond entries in use");

endmodule

[tb/advert_report_dedup_table_tb.sv]
module advert_report_dedup_table_tb import ardt_pkg::*; ();

	localparam int POOL = 24;

	typedef struct packed {
		logic [1:0]        op;
		logic [47:0]       address;
		logic [1:0]        addr_kind;
		logic [2:0]        adv_type;
		logic signed [7:0] rssi;
		logic [4:0]        report_len;
		logic [7:0]        payload_byte;
		logic [3:0]        entry_index;
		logic [4:0]        byte_position;
	} report_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [3:0]        slot;
		logic [47:0]       entry_address;
		logic [1:0]        entry_address_type;
		logic [2:0]        entry_adv_type;
		logic signed [7:0] entry_rssi;
		logic [4:0]        entry_length;
		logic [7:0]        entry_byte;
		logic [4:0]        entry_count;
		logic [31:0]       dropped_count;
	} table_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		report_item_t  item;
		logic          typed;
		table_result_t want;
		logic          scan_val;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         op;
	logic [47:0]        address;
	logic [1:0]         addr_kind;
	logic [2:0]         adv_type;
	logic signed [7:0]  rssi;
	logic [4:0]         report_len;
	logic [7:0]         payload_byte;
	logic [3:0]         entry_index;
	logic [4:0]         byte_position;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic [3:0]         slot;
	logic [47:0]        entry_address;
	logic [1:0]         entry_address_type;
	logic [2:0]         entry_adv_type;
	logic signed [7:0]  entry_rssi;
	logic [4:0]         entry_length;
	logic [7:0]         entry_byte;
	logic [4:0]         entry_count;
	logic [31:0]        dropped_count;

	advert_report_dedup_table DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .address(address), .addr_kind(addr_kind),
		.adv_type(adv_type), .rssi(rssi), .report_len(report_len),
		.payload_byte(payload_byte), .entry_index(entry_index),
		.byte_position(byte_position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot(slot), .entry_address(entry_address),
		.entry_address_type(entry_address_type), .entry_adv_type(entry_adv_type),
		.entry_rssi(entry_rssi), .entry_length(entry_length),
		.entry_byte(entry_byte), .entry_count(entry_count),
		.dropped_count(dropped_count)
	);

	// shadow copy of the table
	logic              scan_on;
	logic [47:0]       tbl_addr  [ENTRIES];
	logic [1:0]        tbl_atype [ENTRIES];
	logic [2:0]        tbl_adv   [ENTRIES];
	logic signed [7:0] tbl_rssi  [ENTRIES];
	logic [4:0]        tbl_len   [ENTRIES];
	logic [7:0]        tbl_bytes [ENTRIES][PAYLOAD_BYTES];
	int                used_cnt;
	logic [31:0]       drop_cnt;
	int                fill_idx;
	int                fill_pos;
	logic              fill_on;

	table_result_t     want_q[$];
	int                errors;
	int                sent_cnt;
	int                send_idle;
	int                recv_idle;

	logic [47:0]       pool_addr  [POOL];
	logic [1:0]        pool_atype [POOL];
	logic [2:0]        pool_adv   [POOL];

	dir_row_t          rows[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	function automatic table_result_t predict_table(input report_item_t it);
		table_result_t r;
		int hit;
		r = '0;
		case (it.op)
			OP_HDR: begin
				if (!scan_on) begin
					r.status = ST_IGNORED;
				end else if (it.report_len > PAYLOAD_BYTES) begin
					fill_on = 1'b0;
					r.status = ST_IGNORED;
				end else begin
					hit = -1;
					for (int i = 0; i < used_cnt; i++)
						if (hit < 0 && tbl_addr[i] == it.address &&
								tbl_atype[i] == it.addr_kind && tbl_adv[i] == it.adv_type)
							hit = i;
					if (hit < 0 && used_cnt >= ENTRIES) begin
						if (drop_cnt != 32'hFFFF_FFFF)
							drop_cnt = drop_cnt + 32'd1;
						fill_on = 1'b0;
						r.status = ST_DROPPED;
					end else begin
						r.status = ST_UPDATED;
						if (hit < 0) begin
							hit = used_cnt;
							used_cnt = used_cnt + 1;
							r.status = ST_NEW;
						end
						tbl_addr[hit]  = it.address;
						tbl_atype[hit] = it.addr_kind;
						tbl_adv[hit]   = it.adv_type;
						tbl_rssi[hit]  = it.rssi;
						tbl_len[hit]   = it.report_len;
						for (int b = 0; b < PAYLOAD_BYTES; b++)
							tbl_bytes[hit][b] = 8'h00;
						fill_idx = hit;
						fill_pos = 0;
						fill_on = (it.report_len != 0);
						r.slot = hit[3:0];
					end
				end
			end
			OP_BYTE: begin
				if (!fill_on || fill_pos >= tbl_len[fill_idx] || fill_pos >= PAYLOAD_BYTES) begin
					fill_on = 1'b0;
					r.status = ST_IGNORED;
				end else begin
					tbl_bytes[fill_idx][fill_pos] = it.payload_byte;
					fill_pos = fill_pos + 1;
					if (fill_pos >= tbl_len[fill_idx])
						fill_on = 1'b0;
					r.status = ST_BYTE;
					r.slot = fill_idx[3:0];
				end
			end
			OP_READ: begin
				r.slot = it.entry_index;
				if (it.entry_index >= used_cnt) begin
					r.status = ST_BAD_IDX;
				end else begin
					r.status             = ST_READ_OK;
					r.entry_address      = tbl_addr[it.entry_index];
					r.entry_address_type = tbl_atype[it.entry_index];
					r.entry_adv_type     = tbl_adv[it.entry_index];
					r.entry_rssi         = tbl_rssi[it.entry_index];
					r.entry_length       = tbl_len[it.entry_index];
					if (it.byte_position < tbl_len[it.entry_index] &&
							it.byte_position < PAYLOAD_BYTES)
						r.entry_byte = tbl_bytes[it.entry_index][it.byte_position];
				end
			end
			default: begin
				used_cnt = 0;
				drop_cnt = '0;
				fill_on = 1'b0;
				fill_pos = 0;
				r.status = ST_UPDATED;
			end
		endcase
		r.entry_count   = used_cnt[4:0];
		r.dropped_count = drop_cnt;
		return r;
	endfunction

	function automatic report_item_t mk(input logic [1:0] o, input logic [47:0] a,
			input logic [1:0] at, input logic [2:0] ty, input logic [7:0] rs,
			input logic [4:0] len, input logic [7:0] by, input logic [3:0] idx,
			input logic [4:0] pos);
		report_item_t it;
		it = '{o, a, at, ty, rs, len, by, idx, pos};
		return it;
	endfunction

	function automatic table_result_t typed_res(input logic [2:0] st, input logic [3:0] sl,
			input logic [4:0] cnt, input logic [31:0] drp);
		table_result_t r;
		r = '0;
		r.status = st;
		r.slot = sl;
		r.entry_count = cnt;
		r.dropped_count = drp;
		return r;
	endfunction

	function automatic report_item_t rand_item();
		report_item_t it;
		it.op             = 2'($urandom_range(3, 0));
		it.address        = 48'({$urandom, $urandom});
		it.addr_kind      = 2'($urandom_range(3, 0));
		it.adv_type       = 3'($urandom_range(4, 0));
		it.rssi           = 8'($urandom_range(255, 0));
		it.report_len     = 5'($urandom_range(31, 0));
		it.payload_byte   = 8'($urandom_range(255, 0));
		it.entry_index    = 4'($urandom_range(15, 0));
		it.byte_position  = 5'($urandom_range(31, 0));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	task automatic push_item(input report_item_t it, input logic typed,
			input table_result_t want);
		table_result_t r;
		while ($urandom_range(99, 0) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		op             = it.op;
		address        = it.address;
		addr_kind      = it.addr_kind;
		adv_type       = it.adv_type;
		rssi           = it.rssi;
		report_len     = it.report_len;
		payload_byte   = it.payload_byte;
		entry_index    = it.entry_index;
		byte_position  = it.byte_position;
		in_valid       = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = predict_table(it);
		sent_cnt++;
		want_q.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic set_scan(input logic v);
		in_valid = 1'b0;
		while (want_q.size() != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = 3'd0; pwdata = {31'b0, v};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		scan_on = v;
		@(negedge clk);
		penable = 1'b0; pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== v)
			report_mismatch("scan_active readback", 64'(prdata), 64'(v));
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	// mostly well-formed header + payload runs over a small key pool, so the
	// table fills, updates and overflows; the rest is reads, clears and noise
	task automatic run_phase(input int target);
		report_item_t it;
		int r;
		int k;
		int nb;
		while (sent_cnt < target) begin
			it = rand_item();
			r = $urandom_range(99, 0);
			if (r < 60) begin
				it.op = OP_HDR;
				if ($urandom_range(99, 0) >= 15) begin
					k = $urandom_range(POOL - 1, 0);
					it.address = pool_addr[k];
					it.addr_kind = pool_atype[k];
					it.adv_type = pool_adv[k];
				end
				if ($urandom_range(99, 0) < 70)
					it.report_len = 5'($urandom_range(6, 0));
				push_item(it, 1'b0, '0);
				nb = int'(it.report_len);
				k = $urandom_range(99, 0);
				if (k < 15)
					nb = $urandom_range(it.report_len, 0);
				else if (k < 25)
					nb = nb + $urandom_range(2, 1);
				for (int b = 0; b < nb; b++) begin
					it = rand_item();
					it.op = OP_BYTE;
					push_item(it, 1'b0, '0);
				end
			end else if (r < 85) begin
				it.op = OP_READ;
				if ($urandom_range(99, 0) < 80)
					it.byte_position = 5'($urandom_range(7, 0));
				push_item(it, 1'b0, '0);
			end else if (r < 87) begin
				it.op = OP_CLEAR;
				push_item(it, 1'b0, '0);
			end else begin
				push_item(it, 1'b0, '0);
			end
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99, 0) >= recv_idle);

	always @(posedge clk) begin : result_check
		table_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (want_q.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(status), 64'd0);
			end else begin
				w = want_q.pop_front();
				if (status !== w.status)
					report_mismatch("status", 64'(status), 64'(w.status));
				if (slot !== w.slot)
					report_mismatch("slot", 64'(slot), 64'(w.slot));
				if (entry_address !== w.entry_address)
					report_mismatch("entry_address", 64'(entry_address),
						64'(w.entry_address));
				if (entry_address_type !== w.entry_address_type)
					report_mismatch("entry_address_type", 64'(entry_address_type),
						64'(w.entry_address_type));
				if (entry_adv_type !== w.entry_adv_type)
					report_mismatch("entry_adv_type", 64'(entry_adv_type),
						64'(w.entry_adv_type));
				if (entry_rssi !== w.entry_rssi)
					report_mismatch("entry_rssi", 64'(entry_rssi), 64'(w.entry_rssi));
				if (entry_length !== w.entry_length)
					report_mismatch("entry_length", 64'(entry_length), 64'(w.entry_length));
				if (entry_byte !== w.entry_byte)
					report_mismatch("entry_byte", 64'(entry_byte), 64'(w.entry_byte));
				if (entry_count !== w.entry_count)
					report_mismatch("entry_count", 64'(entry_count), 64'(w.entry_count));
				if (dropped_count !== w.dropped_count)
					report_mismatch("dropped_count", 64'(dropped_count),
						64'(w.dropped_count));
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0;
		op = OP_HDR; address = '0; addr_kind = '0; adv_type = '0; rssi = '0;
		report_len = '0; payload_byte = '0; entry_index = '0; byte_position = '0;
		out_ready = 1'b0;
		errors = 0; sent_cnt = 0;
		send_idle = 20; recv_idle = 51;
		scan_on = 1'b0; used_cnt = 0; drop_cnt = '0;
		fill_idx = 0; fill_pos = 0; fill_on = 1'b0;
		for (int k = 0; k < POOL; k++) begin
			pool_addr[k]  = (k < 8) ? 48'({$urandom, $urandom}) : pool_addr[k % 8];
			pool_atype[k] = 2'(k / 8);
			pool_adv[k]   = 3'($urandom_range(4, 0));
		end

		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, typed_res(ST_BAD_IDX, 0, 0, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_HDR, 48'h1234_5678_9ABC, 1, 2, 8'h10, 4, 0, 0, 0),
			1'b1, typed_res(ST_IGNORED, 0, 0, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'h77, 0, 0),
			1'b1, typed_res(ST_IGNORED, 0, 0, 0), 1'b0});
		rows.push_back('{ROW_CFG, '0, 1'b0, '0, 1'b1});
		rows.push_back('{ROW_ITEM, mk(OP_HDR, 48'hFFFF_FFFF_FFFF, 3, 4, 8'h80, 31, 0, 0, 0),
			1'b1, typed_res(ST_NEW, 0, 1, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'hFF, 0, 0), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'h00, 0, 0), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'hA5, 0, 0), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 2), 1'b0, '0, 1'b0});
		// header abandons the open fill; zero length opens none
		rows.push_back('{ROW_ITEM, mk(OP_HDR, 48'h0, 0, 0, 8'h7F, 0, 0, 0, 0),
			1'b1, typed_res(ST_NEW, 1, 2, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'h11, 0, 0),
			1'b1, typed_res(ST_IGNORED, 0, 2, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_HDR, 48'hFFFF_FFFF_FFFF, 3, 4, 8'h00, 2, 0, 0, 0),
			1'b1, typed_res(ST_UPDATED, 0, 2, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'h5A, 0, 0), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'hC3, 0, 0), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_BYTE, 0, 0, 0, 0, 0, 8'h99, 0, 0),
			1'b1, typed_res(ST_IGNORED, 0, 2, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 2), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 31), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0, 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 15, 30),
			1'b1, typed_res(ST_BAD_IDX, 15, 2, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, typed_res(ST_UPDATED, 0, 0, 0), 1'b0});
		rows.push_back('{ROW_ITEM, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, typed_res(ST_BAD_IDX, 0, 0, 0), 1'b0});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				set_scan(rows[i].scan_val);
			else
				push_item(rows[i].item, rows[i].typed, rows[i].want);
		end

		run_phase(sent_cnt + 330);
		set_scan(1'b0);
		run_phase(sent_cnt + 120);
		set_scan(1'b1);
		send_idle = 51; recv_idle = 20;
		run_phase(sent_cnt + 300);
		send_idle = 0; recv_idle = 0;
		run_phase(sent_cnt + 250);

		in_valid = 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ardt_pkg.sv
hw/rtl/ardt_tbl.sv
hw/rtl/advert_report_dedup_table.sv
tb/advert_report_dedup_table_tb.sv
